>>> hdl/sha256_pkg.sv
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;
  localparam logic [63:0] BlockBits = 64'd512;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hdl/sha256_buf.sv
// 16x32 block buffer, byte-writable, one read port with registered data.
module sha256_buf (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [3:0]  wbe_i,
  input  logic [31:0] wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [31:0] rdata_o
);
  logic [31:0] mem [16];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < 4; b++) begin
        if (wbe_i[b]) mem[waddr_i][b*8 +: 8] <= wdata_i[b*8 +: 8];
      end
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> hdl/sha256_core.sv
// One round per cycle; message schedule in a 16-word window.
module sha256_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] h_i [8],
  input  logic [31:0] w_i,
  output logic [3:0]  waddr_o,
  output logic        done_o,
  output logic [31:0] v_o [8]
);
  import sha256_pkg::*;

  logic [6:0]  rnd_q, rnd_d;
  logic        busy_q, busy_d;
  logic [31:0] v_q [8];
  logic [31:0] win_q [16];
  logic [31:0] wr, s0, s1, b0, b1, ch, mj, t1, t2, wn;

  assign waddr_o = rnd_d[3:0];
  assign v_o = v_q;

  always_comb begin
    s0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    wn = s1 + win_q[9] + s0 + win_q[0];
    wr = (rnd_q < 7'd16) ? w_i : wn;
    b1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    b0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1 = v_q[7] + b1 + ch + K[rnd_q[5:0]] + wr;
    t2 = b0 + mj;
    busy_d = busy_q;
    rnd_d = rnd_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      rnd_d = '0;
    end else if (busy_q) begin
      rnd_d = rnd_q + 7'd1;
      if (rnd_q == 7'd63) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q <= '0;
    end else begin
      busy_q <= busy_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= h_i;
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= wr;
    end
  end
endmodule

>>> hdl/sha256_byte_stream_hasher_top.sv
// SHA-256 over a byte stream. A data beat (cmd 0) writes one byte into the block
// memory; the 64th byte of a block starts a compression of 64 rounds, one per
// cycle, after the load state and before the update state, so no beat is taken
// until the compression is through. A finish beat (cmd 1) writes the padding one
// word per cycle, runs one or two compressions, then presents the eight digest words
// (index 0 first, last on index 7) and returns to the initial hash values.
module sha256_byte_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_o
);
  import sha256_pkg::*;

  state_e      st_q, st_d;
  logic [31:0] h_q [8];
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [63:0] tot_q, tot_d;
  logic        fin_q, fin_d;   // finishing: padding pass in progress
  logic        two_q, two_d;   // padding needs a second block
  logic        sec_q, sec_d;   // second-block load pass
  logic [4:0]  pw_q, pw_d;     // padding word pointer
  logic [2:0]  oi_q, oi_d;
  logic        we;
  logic [3:0]  waddr, wbe, raddr, caddr;
  logic [31:0] wdata, rdata;
  logic        start, done, upd;
  logic [31:0] v [8];

  sha256_buf u_buf (
    .clk_i, .we_i(we), .waddr_i(waddr), .wbe_i(wbe), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  sha256_core u_core (
    .clk_i, .rst_ni, .start_i(start), .h_i(h_q), .w_i(rdata),
    .waddr_o(caddr), .done_o(done), .v_o(v)
  );

  assign raddr = caddr;
  assign ready_o = (st_q == ST_IDLE);
  assign valid_o = (st_q == ST_EMIT);
  assign digest_word_o = h_q[oi_q];
  assign word_index_o = oi_q;
  assign last_o = (oi_q == 3'd7);

  // padding word pw (0..15): byte lanes below cnt keep data, at cnt get 0x80
  // second block pointer runs 16..31 mapped onto words 0..15, ends on wrap to 0
  always_comb begin
    logic [5:0] bi;
    logic [31:0] pd;
    st_d = st_q; cnt_d = cnt_q; len_d = len_q; tot_d = tot_q;
    fin_d = fin_q; two_d = two_q; pw_d = pw_q; oi_d = oi_q;
    we = 1'b0; waddr = cnt_q[5:2]; wbe = '0; wdata = '0;
    start = 1'b0; upd = 1'b0;
    pd = '0;
    bi = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (!cmd_i) begin
            we = 1'b1;
            waddr = cnt_q[5:2];
            wbe = 4'b1000 >> cnt_q[1:0];
            wdata = {4{data_byte_i}};
            cnt_d = cnt_q + 6'd1;
            if (cnt_q == 6'd63) st_d = ST_LOAD;
          end else begin
            fin_d = 1'b1;
            two_d = (cnt_q >= LenPos);
            tot_d = len_q + {55'd0, cnt_q, 3'd0};
            pw_d = {1'b0, cnt_q[5:2]};
            st_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (fin_q && (sec_q ? (pw_q != 5'd0) : (pw_q != 5'd16))) begin
          we = 1'b1;
          waddr = pw_q[3:0];
          for (int b = 0; b < 4; b++) begin
            bi = {pw_q[3:0], 2'(b)};
            if (pw_q[4]) pd[31-8*b -: 8] = 8'h00;
            else if (bi == cnt_q) pd[31-8*b -: 8] = PadByte;
            else pd[31-8*b -: 8] = 8'h00;
            wbe[3-b] = (bi >= cnt_q) || pw_q[4];
          end
          if (!two_q && pw_q[3:0] == 4'd14) pd = tot_q[63:32];
          if (!two_q && pw_q[3:0] == 4'd15) pd = tot_q[31:0];
          if (!two_q && pw_q[3:1] == 3'b111) wbe = 4'hf;
          wdata = pd;
          pw_d = pw_q + 5'd1;
        end else begin
          start = 1'b1;
          st_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (done) st_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        upd = 1'b1;
        if (!fin_q) begin
          len_d = len_q + BlockBits;
          cnt_d = '0;
          st_d = ST_IDLE;
        end else if (two_q) begin
          two_d = 1'b0;
          cnt_d = '0;
          pw_d = 5'd16;   // second block: full zero words, then length
          st_d = ST_LOAD;
        end else begin
          oi_d = '0;
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ready_i) begin
          oi_d = oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            fin_d = 1'b0;
            cnt_d = '0;
            len_d = '0;
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sec_d = sec_q;
    if (st_q == ST_UPDATE) sec_d = two_q;
    else if (st_q == ST_IDLE) sec_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      cnt_q <= '0;
      len_q <= '0;
      fin_q <= 1'b0;
      two_q <= 1'b0;
      pw_q <= '0;
      oi_q <= '0;
      sec_q <= 1'b0;
      tot_q <= '0;
      h_q <= IV;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      len_q <= len_d;
      fin_q <= fin_d;
      two_q <= two_d;
      oi_q <= oi_d;
      sec_q <= sec_d;
      tot_q <= tot_d;
      pw_q <= pw_d;
      if (upd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v[i];
      end else if (st_q == ST_EMIT && ready_i && oi_q == 3'd7) begin
        h_q <= IV;
      end
    end
  end
endmodule
